/* rtl/core/slot_pool_free_list_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Slot pool allocator assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_FREE_LIST_ALLOCATOR_MACROS_SVH

// Check cons in the same cycle as ant.
`define SPFL_ASSERT_SAME(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ant.
`define SPFL_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/spfl_pkg.sv */
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Sizes, action and status codes, datapath select codes and the command and
// status bundles that join controller and datapath.
// ----------------------------------------------------------------------------
package spfl_pkg;

    localparam int POOL_SLOTS = 32;
    localparam int LAST_SLOT  = POOL_SLOTS - 1;
    localparam int ADDR_W     = $clog2(POOL_SLOTS);
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
    localparam int ACT_W      = 2;
    localparam int SLOT_W     = 5;
    localparam int LINK_W     = 6;
    localparam int STAT_W     = 2;

    localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(POOL_SLOTS);

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 2'd2;

    // read address select
    localparam logic [2:0] RD_FREE = 3'd0;
    localparam logic [2:0] RD_USED = 3'd1;
    localparam logic [2:0] RD_CUR  = 3'd2;
    localparam logic [2:0] RD_LINK = 3'd3;
    localparam logic [2:0] RD_SLOT = 3'd4;

    // free head load select
    localparam logic FH_LINK = 1'b0;
    localparam logic FH_CUR  = 1'b1;

    // in-use head load select
    localparam logic UH_GOT  = 1'b0;
    localparam logic UH_LINK = 1'b1;

    // walk pointer select
    localparam logic [1:0] CUR_HOLD = 2'd0;
    localparam logic [1:0] CUR_USED = 2'd1;
    localparam logic [1:0] CUR_LINK = 2'd2;

    // predecessor select
    localparam logic [1:0] PREV_HOLD = 2'd0;
    localparam logic [1:0] PREV_NONE = 2'd1;
    localparam logic [1:0] PREV_CUR  = 2'd2;

    // write address select
    localparam logic [1:0] WA_CUR  = 2'd0;
    localparam logic [1:0] WA_GOT  = 2'd1;
    localparam logic [1:0] WA_PREV = 2'd2;

    // write data select
    localparam logic [1:0] WD_GOT  = 2'd0;
    localparam logic [1:0] WD_NONE = 2'd1;
    localparam logic [1:0] WD_LINK = 2'd2;
    localparam logic [1:0] WD_FREE = 2'd3;

    // result slot select
    localparam logic [1:0] RS_NONE = 2'd0;
    localparam logic [1:0] RS_GOT  = 2'd1;
    localparam logic [1:0] RS_CUR  = 2'd2;
    localparam logic [1:0] RS_LINK = 2'd3;

    typedef struct packed {
        logic              load_in;
        logic              rd_en;
        logic [2:0]        rd_sel;
        logic              got_ld;
        logic              free_ld;
        logic              free_sel;
        logic              used_ld;
        logic              used_sel;
        logic [1:0]        cur_sel;
        logic [1:0]        prev_sel;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              wr_en;
        logic [1:0]        wa_sel;
        logic [1:0]        wd_sel;
        logic              res_ld;
        logic [1:0]        res_sel;
        logic [STAT_W-1:0] res_status;
        logic              out_ld;
    } spfl_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             fh_is_slot;
        logic             uh_is_slot;
        logic             link_is_slot;
        logic             cur_is_slot;
        logic             cur_eq_slot;
        logic             prev_is_slot;
        logic             slot_is_slot;
        logic             cnt_lt_n;
    } spfl_stat_t;

endpackage

/* rtl/core/spfl_dpath.sv */
// ----------------------------------------------------------------------------
// Slot pool allocator datapath
// Link table memory, list heads, walk pointers, walk counter and the result
// and output registers, all steered by controller commands.
// ----------------------------------------------------------------------------
module spfl_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spfl_pkg::spfl_cmd_t           cmd,
    output spfl_pkg::spfl_stat_t          stat,
    input  logic [spfl_pkg::ACT_W-1:0]    s_action,
    input  logic [spfl_pkg::SLOT_W-1:0]   s_slot,
    output logic [spfl_pkg::LINK_W-1:0]   m_slot_out,
    output logic [spfl_pkg::STAT_W-1:0]   m_status,
    output logic [spfl_pkg::LINK_W-1:0]   m_used_head
);

    logic [spfl_pkg::LINK_W-1:0] link_mem [spfl_pkg::POOL_SLOTS];
    logic [spfl_pkg::POOL_SLOTS-1:0] vld_reg;

    logic [spfl_pkg::ACT_W-1:0]  act_reg;
    logic [spfl_pkg::SLOT_W-1:0] slot_reg;
    logic [spfl_pkg::LINK_W-1:0] got_reg;
    logic [spfl_pkg::LINK_W-1:0] free_head_reg;
    logic [spfl_pkg::LINK_W-1:0] used_head_reg;
    logic [spfl_pkg::LINK_W-1:0] cur_reg;
    logic [spfl_pkg::LINK_W-1:0] cur_next;
    logic [spfl_pkg::LINK_W-1:0] prev_reg;
    logic [spfl_pkg::CNT_W-1:0]  cnt_reg;
    logic [spfl_pkg::LINK_W-1:0] res_reg;
    logic [spfl_pkg::LINK_W-1:0] res_next;
    logic [spfl_pkg::STAT_W-1:0] res_status_reg;
    logic [spfl_pkg::LINK_W-1:0] m_slot_out_reg;
    logic [spfl_pkg::STAT_W-1:0] m_status_reg;
    logic [spfl_pkg::LINK_W-1:0] m_used_head_reg;

    logic [spfl_pkg::LINK_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;
    logic [spfl_pkg::LINK_W-1:0] rd_dflt_reg;
    logic [spfl_pkg::LINK_W-1:0] rdata;

    logic [spfl_pkg::ADDR_W-1:0] rd_addr;
    logic [spfl_pkg::ADDR_W-1:0] wr_addr;
    logic [spfl_pkg::LINK_W-1:0] wr_data;
    logic [spfl_pkg::LINK_W-1:0] rd_dflt;

    // unwritten entries read as their reset link
    assign rdata = rd_vld_reg ? rd_data_reg : rd_dflt_reg;

    always_comb begin
        case (cmd.rd_sel)
            spfl_pkg::RD_FREE: rd_addr = free_head_reg[spfl_pkg::ADDR_W-1:0];
            spfl_pkg::RD_USED: rd_addr = used_head_reg[spfl_pkg::ADDR_W-1:0];
            spfl_pkg::RD_CUR:  rd_addr = cur_reg[spfl_pkg::ADDR_W-1:0];
            spfl_pkg::RD_LINK: rd_addr = rdata[spfl_pkg::ADDR_W-1:0];
            spfl_pkg::RD_SLOT: rd_addr = spfl_pkg::ADDR_W'(slot_reg);
            default:           rd_addr = cur_reg[spfl_pkg::ADDR_W-1:0];
        endcase
    end

    always_comb begin
        if (rd_addr == spfl_pkg::ADDR_W'(spfl_pkg::LAST_SLOT)) begin
            rd_dflt = spfl_pkg::NONE_SLOT;
        end else begin
            rd_dflt = spfl_pkg::LINK_W'(rd_addr) + spfl_pkg::LINK_W'(1);
        end
    end

    always_comb begin
        case (cmd.wa_sel)
            spfl_pkg::WA_CUR:  wr_addr = cur_reg[spfl_pkg::ADDR_W-1:0];
            spfl_pkg::WA_GOT:  wr_addr = got_reg[spfl_pkg::ADDR_W-1:0];
            spfl_pkg::WA_PREV: wr_addr = prev_reg[spfl_pkg::ADDR_W-1:0];
            default:           wr_addr = cur_reg[spfl_pkg::ADDR_W-1:0];
        endcase
        case (cmd.wd_sel)
            spfl_pkg::WD_GOT:  wr_data = got_reg;
            spfl_pkg::WD_NONE: wr_data = spfl_pkg::NONE_SLOT;
            spfl_pkg::WD_LINK: wr_data = rdata;
            spfl_pkg::WD_FREE: wr_data = free_head_reg;
            default:           wr_data = spfl_pkg::NONE_SLOT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= link_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            rd_dflt_reg <= rd_dflt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            used_head_reg <= spfl_pkg::NONE_SLOT;
        end else begin
            if (cmd.free_ld) begin
                free_head_reg <= (cmd.free_sel == spfl_pkg::FH_CUR) ? cur_reg : rdata;
            end
            if (cmd.used_ld) begin
                used_head_reg <= (cmd.used_sel == spfl_pkg::UH_LINK) ? rdata : got_reg;
            end
        end
    end

    always_comb begin
        case (cmd.cur_sel)
            spfl_pkg::CUR_USED: cur_next = used_head_reg;
            spfl_pkg::CUR_LINK: cur_next = rdata;
            default:            cur_next = cur_reg;
        endcase
        case (cmd.res_sel)
            spfl_pkg::RS_GOT:  res_next = got_reg;
            spfl_pkg::RS_CUR:  res_next = cur_reg;
            spfl_pkg::RS_LINK: res_next = rdata;
            default:           res_next = spfl_pkg::NONE_SLOT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg  <= s_action;
            slot_reg <= s_slot;
        end
        if (cmd.got_ld) begin
            got_reg <= free_head_reg;
        end
        cur_reg <= cur_next;
        case (cmd.prev_sel)
            spfl_pkg::PREV_NONE: prev_reg <= spfl_pkg::NONE_SLOT;
            spfl_pkg::PREV_CUR:  prev_reg <= cur_reg;
            default:             prev_reg <= prev_reg;
        endcase
        if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + spfl_pkg::CNT_W'(1);
        end
        if (cmd.res_ld) begin
            res_reg        <= res_next;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_ld) begin
            m_slot_out_reg  <= res_reg;
            m_status_reg    <= res_status_reg;
            m_used_head_reg <= used_head_reg;
        end
    end

    assign m_slot_out  = m_slot_out_reg;
    assign m_status    = m_status_reg;
    assign m_used_head = m_used_head_reg;

    assign stat.act          = act_reg;
    assign stat.fh_is_slot   = free_head_reg < spfl_pkg::NONE_SLOT;
    assign stat.uh_is_slot   = used_head_reg < spfl_pkg::NONE_SLOT;
    assign stat.link_is_slot = rdata < spfl_pkg::NONE_SLOT;
    assign stat.cur_is_slot  = cur_reg < spfl_pkg::NONE_SLOT;
    assign stat.cur_eq_slot  = cur_reg == spfl_pkg::LINK_W'(slot_reg);
    assign stat.prev_is_slot = prev_reg < spfl_pkg::NONE_SLOT;
    assign stat.slot_is_slot = spfl_pkg::LINK_W'(slot_reg) < spfl_pkg::NONE_SLOT;
    assign stat.cnt_lt_n     = cnt_reg < spfl_pkg::CNT_W'(spfl_pkg::POOL_SLOTS);

endmodule

/* rtl/core/spfl_ctrl.sv */
// ----------------------------------------------------------------------------
// Slot pool allocator controller
// Sequences allocate, free and read over the link table one memory access a
// cycle and owns both handshakes.
// ----------------------------------------------------------------------------
module spfl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  spfl_pkg::spfl_stat_t stat,
    output spfl_pkg::spfl_cmd_t  cmd
);

`include "slot_pool_free_list_allocator_macros.svh"

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_A_POP    = 4'd2;
    localparam logic [3:0] S_A_WALK   = 4'd3;
    localparam logic [3:0] S_A_TERM   = 4'd4;
    localparam logic [3:0] S_F_CHK    = 4'd5;
    localparam logic [3:0] S_F_STEP   = 4'd6;
    localparam logic [3:0] S_F_UNLINK = 4'd7;
    localparam logic [3:0] S_F_PUSH   = 4'd8;
    localparam logic [3:0] S_R_WAIT   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.act)
                    spfl_pkg::ACT_ALLOC: begin
                        if (!stat.fh_is_slot) begin
                            cmd.res_ld     = 1'b1;
                            cmd.res_sel    = spfl_pkg::RS_NONE;
                            cmd.res_status = spfl_pkg::ST_EMPTY;
                            state_next     = S_DONE;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = spfl_pkg::RD_FREE;
                            cmd.got_ld = 1'b1;
                            state_next = S_A_POP;
                        end
                    end
                    spfl_pkg::ACT_FREE: begin
                        cmd.cur_sel  = spfl_pkg::CUR_USED;
                        cmd.prev_sel = spfl_pkg::PREV_NONE;
                        cmd.cnt_clr  = 1'b1;
                        state_next   = S_F_CHK;
                    end
                    spfl_pkg::ACT_READ: begin
                        if (stat.slot_is_slot) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = spfl_pkg::RD_SLOT;
                            state_next = S_R_WAIT;
                        end else begin
                            cmd.res_ld     = 1'b1;
                            cmd.res_sel    = spfl_pkg::RS_NONE;
                            cmd.res_status = spfl_pkg::ST_OK;
                            state_next     = S_DONE;
                        end
                    end
                    default: begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_sel    = spfl_pkg::RS_NONE;
                        cmd.res_status = spfl_pkg::ST_OK;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_A_POP: begin
                cmd.free_ld  = 1'b1;
                cmd.free_sel = spfl_pkg::FH_LINK;
                if (!stat.uh_is_slot) begin
                    cmd.used_ld  = 1'b1;
                    cmd.used_sel = spfl_pkg::UH_GOT;
                    state_next   = S_A_TERM;
                end else begin
                    cmd.cur_sel = spfl_pkg::CUR_USED;
                    cmd.cnt_clr = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = spfl_pkg::RD_USED;
                    state_next  = S_A_WALK;
                end
            end
            S_A_WALK: begin
                if (stat.cnt_lt_n && stat.link_is_slot) begin
                    cmd.cur_sel = spfl_pkg::CUR_LINK;
                    cmd.cnt_inc = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = spfl_pkg::RD_LINK;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = spfl_pkg::WA_CUR;
                    cmd.wd_sel = spfl_pkg::WD_GOT;
                    state_next = S_A_TERM;
                end
            end
            S_A_TERM: begin
                cmd.wr_en      = 1'b1;
                cmd.wa_sel     = spfl_pkg::WA_GOT;
                cmd.wd_sel     = spfl_pkg::WD_NONE;
                cmd.res_ld     = 1'b1;
                cmd.res_sel    = spfl_pkg::RS_GOT;
                cmd.res_status = spfl_pkg::ST_OK;
                state_next     = S_DONE;
            end
            S_F_CHK: begin
                if (stat.cnt_lt_n && stat.cur_is_slot && !stat.cur_eq_slot) begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = spfl_pkg::RD_CUR;
                    cmd.prev_sel = spfl_pkg::PREV_CUR;
                    state_next   = S_F_STEP;
                end else if (stat.cur_is_slot && stat.cur_eq_slot) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = spfl_pkg::RD_CUR;
                    state_next = S_F_UNLINK;
                end else begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_sel    = spfl_pkg::RS_NONE;
                    cmd.res_status = spfl_pkg::ST_NOT_USED;
                    state_next     = S_DONE;
                end
            end
            S_F_STEP: begin
                cmd.cur_sel = spfl_pkg::CUR_LINK;
                cmd.cnt_inc = 1'b1;
                state_next  = S_F_CHK;
            end
            S_F_UNLINK: begin
                if (!stat.prev_is_slot) begin
                    cmd.used_ld  = 1'b1;
                    cmd.used_sel = spfl_pkg::UH_LINK;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = spfl_pkg::WA_PREV;
                    cmd.wd_sel = spfl_pkg::WD_LINK;
                end
                state_next = S_F_PUSH;
            end
            S_F_PUSH: begin
                cmd.wr_en      = 1'b1;
                cmd.wa_sel     = spfl_pkg::WA_CUR;
                cmd.wd_sel     = spfl_pkg::WD_FREE;
                cmd.free_ld    = 1'b1;
                cmd.free_sel   = spfl_pkg::FH_CUR;
                cmd.res_ld     = 1'b1;
                cmd.res_sel    = spfl_pkg::RS_CUR;
                cmd.res_status = spfl_pkg::ST_OK;
                state_next     = S_DONE;
            end
            S_R_WAIT: begin
                cmd.res_ld     = 1'b1;
                cmd.res_sel    = spfl_pkg::RS_LINK;
                cmd.res_status = spfl_pkg::ST_OK;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `SPFL_ASSERT_SAME(a_out_ld_free, cmd.out_ld, !m_valid_reg || m_ready,
        "output register overwritten while a beat waits")
    `SPFL_ASSERT_NEXT(a_accept_decode, s_valid && s_ready, state_reg == S_DECODE,
        "accepted beat not decoded next cycle")
    `SPFL_ASSERT_SAME(a_one_access, cmd.wr_en, !cmd.rd_en,
        "link table read and written in one cycle")

endmodule

/* rtl/core/slot_pool_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// Slot pool free-list allocator
// Allocates and frees slots of a fixed pool over one shared link table and
// keeps the in-use slots in allocation order.
// ----------------------------------------------------------------------------
// One item is worked at a time; each takes one result beat. Allocate
// walks the in-use list to its tail one link read a cycle when that list
// is not empty, and free pays a link read and a compare step for every slot
// ahead of the freed one in its predecessor search on the link table. A
// failed allocate or free also reports through the result beat. After the
// result is loaded the block is ready again in the next cycle, and a
// finished result may wait in the output register while the next item is
// accepted and worked.
// ----------------------------------------------------------------------------
module slot_pool_free_list_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [spfl_pkg::ACT_W-1:0]  s_action,
    input  logic [spfl_pkg::SLOT_W-1:0] s_slot,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [spfl_pkg::LINK_W-1:0] m_slot_out,
    output logic [spfl_pkg::STAT_W-1:0] m_status,
    output logic [spfl_pkg::LINK_W-1:0] m_used_head
);

    // controller to datapath commands, datapath to controller flags
    spfl_pkg::spfl_cmd_t  cmd;
    spfl_pkg::spfl_stat_t stat;

    // sequence each action and own the two handshakes
    spfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // hold the link table, both list heads, walk pointers and result beat
    spfl_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_action    (s_action),
        .s_slot      (s_slot),
        .m_slot_out  (m_slot_out),
        .m_status    (m_status),
        .m_used_head (m_used_head)
    );

endmodule
